@@ hw/rtl/tsps_pkg.sv @@
// Package for the timed servo pose sequencer.
// Holds event and sequence codes, command and run types, delays and queue sizing.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsps_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned MAX_CMDS       = 3;

  localparam int unsigned DLY_100 = 100;
  localparam int unsigned DLY_200 = 200;
  localparam int unsigned DLY_300 = 300;
  localparam int unsigned DLY_400 = 400;
  localparam int unsigned DLY_500 = 500;
  localparam int unsigned DLY_600 = 600;

  localparam logic [1:0] SHAKE_ROUNDS = 2'd3;

  typedef enum logic [2:0] {
    OP_TICK          = 3'd0,
    OP_START_CAR     = 3'd1,
    OP_START_CRAWLER = 3'd2,
    OP_RECOVER       = 3'd3,
    OP_STOP          = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    FALL_NONE  = 2'd0,
    FALL_FRONT = 2'd1,
    FALL_REAR  = 2'd2,
    FALL_SHAKE = 2'd3
  } fall_e;

  typedef enum logic [2:0] {
    SEQ_IDLE    = 3'd0,
    SEQ_CAR     = 3'd1,
    SEQ_CRAWLER = 3'd2,
    SEQ_FWD     = 3'd3,
    SEQ_BACK    = 3'd4,
    SEQ_SHAKE   = 3'd5
  } seq_e;

  typedef enum logic {
    KIND_MOVE  = 1'b0,
    KIND_STAND = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [4:0] chan;
    logic [7:0] angle;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          count;
    cmd_t [MAX_CMDS-1:0] cmds;
  } run_t;

  function automatic cmd_t mv(input logic [4:0] chan, input logic [7:0] angle);
    cmd_t c;
    c.kind  = KIND_MOVE;
    c.chan  = chan;
    c.angle = angle;
    return c;
  endfunction

  function automatic cmd_t stand_cmd();
    cmd_t c;
    c.kind  = KIND_STAND;
    c.chan  = 5'd0;
    c.angle = 8'd0;
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tsps_front.sv @@
// Front end of the timed servo pose sequencer: takes events, keeps sequence state
// and turns each event into a run of up to three commands. Uses tsps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsps_front
  import tsps_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        ev_valid_i,
  output logic             ev_ready_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [1:0]  fall_dir_i,
  input  wire logic [31:0] now_ms_i,
  output logic             push_o,
  output run_t             run_o,
  input  wire logic        full_i
);

  seq_e                  seq_q, seq_d;
  logic [2:0]            step_q, step_d;
  logic [TIME_WIDTH-1:0] last_q, last_d;
  logic [1:0]            shake_q, shake_d;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] el;
  logic [1:0]            sc_inc;
  logic                  accept;
  run_t                  run;

  generate
    if (TIME_WIDTH > 32) begin : g_wide
      assign now = {{(TIME_WIDTH - 32){1'b0}}, now_ms_i};
    end else if (TIME_WIDTH == 32) begin : g_same
      assign now = now_ms_i;
    end else begin : g_narrow
      assign now = now_ms_i[TIME_WIDTH-1:0];
    end
  endgenerate

  assign el         = now - last_q;
  assign sc_inc     = shake_q + 2'd1;
  assign ev_ready_o = !full_i;
  assign accept     = ev_valid_i && ev_ready_o;
  assign run_o      = run;
  assign push_o     = accept && (run.count != 2'd0);

  always_comb begin
    seq_d   = seq_q;
    step_d  = step_q;
    last_d  = last_q;
    shake_d = shake_q;
    run     = '0;
    case (op_e'(opcode_i))
      OP_TICK: begin
        case (seq_q)
          SEQ_IDLE: begin
          end
          SEQ_CAR: begin
            if (step_q == 3'd0 && el >= TIME_WIDTH'(DLY_300)) begin
              run.cmds[0] = mv(5'd24, 8'd0);
              run.count   = 2'd1;
              step_d      = step_q + 3'd1;
              last_d      = now;
            end else if (step_q == 3'd1 && el >= TIME_WIDTH'(DLY_500)) begin
              run.cmds[0] = mv(5'd14, 8'd0);
              run.cmds[1] = mv(5'd20, 8'd180);
              run.count   = 2'd2;
              step_d      = step_q + 3'd1;
              last_d      = now;
            end else if (step_q == 3'd2 && el >= TIME_WIDTH'(DLY_500)) begin
              run.cmds[0] = mv(5'd15, 8'd0);
              run.cmds[1] = mv(5'd21, 8'd180);
              run.count   = 2'd2;
              step_d      = step_q + 3'd1;
              last_d      = now;
            end else if (step_q == 3'd3 && el >= TIME_WIDTH'(DLY_500)) begin
              run.cmds[0] = mv(5'd2, 8'd0);
              run.cmds[1] = mv(5'd8, 8'd180);
              run.count   = 2'd2;
              step_d      = step_q + 3'd1;
              last_d      = now;
            end else if (step_q == 3'd4 && el >= TIME_WIDTH'(DLY_500)) begin
              run.cmds[0] = mv(5'd3, 8'd180);
              run.cmds[1] = mv(5'd9, 8'd0);
              run.count   = 2'd2;
              step_d      = step_q + 3'd1;
              last_d      = now;
            end else if (step_q == 3'd5 && el >= TIME_WIDTH'(DLY_600)) begin
              run.cmds[0] = mv(5'd4, 8'd90);
              run.cmds[1] = mv(5'd10, 8'd90);
              run.cmds[2] = mv(5'd26, 8'd0);
              run.count   = 2'd3;
              seq_d       = SEQ_IDLE;
            end
          end
          SEQ_CRAWLER: begin
            if (step_q == 3'd0 && el >= TIME_WIDTH'(DLY_300)) begin
              run.cmds[0] = mv(5'd2, 8'd160);
              run.cmds[1] = mv(5'd3, 8'd20);
              run.count   = 2'd2;
              step_d      = step_q + 3'd1;
              last_d      = now;
            end else if (step_q == 3'd1 && el >= TIME_WIDTH'(DLY_300)) begin
              run.cmds[0] = mv(5'd4, 8'd150);
              run.cmds[1] = mv(5'd5, 8'd30);
              run.count   = 2'd2;
              step_d      = step_q + 3'd1;
              last_d      = now;
            end else if (step_q == 3'd2 && el >= TIME_WIDTH'(DLY_200)) begin
              seq_d = SEQ_IDLE;
            end
          end
          SEQ_FWD: begin
            if (step_q == 3'd0 && el >= TIME_WIDTH'(DLY_500)) begin
              run.cmds[0] = mv(5'd4, 8'd40);
              run.cmds[1] = mv(5'd5, 8'd140);
              run.count   = 2'd2;
              step_d      = step_q + 3'd1;
              last_d      = now;
            end else if (step_q == 3'd1 && el >= TIME_WIDTH'(DLY_300)) begin
              run.cmds[0] = stand_cmd();
              run.count   = 2'd1;
              seq_d       = SEQ_IDLE;
            end
          end
          SEQ_BACK: begin
            if (step_q == 3'd0 && el >= TIME_WIDTH'(DLY_400)) begin
              run.cmds[0] = mv(5'd2, 8'd160);
              run.cmds[1] = mv(5'd3, 8'd20);
              run.count   = 2'd2;
              step_d      = step_q + 3'd1;
              last_d      = now;
            end else if (step_q == 3'd1 && el >= TIME_WIDTH'(DLY_300)) begin
              run.cmds[0] = stand_cmd();
              run.count   = 2'd1;
              seq_d       = SEQ_IDLE;
            end
          end
          SEQ_SHAKE: begin
            if (el >= TIME_WIDTH'(DLY_100)) begin
              last_d = now;
              if (step_q == 3'd0) begin
                run.cmds[0] = mv(5'd4, 8'd140);
                run.cmds[1] = mv(5'd5, 8'd40);
                run.count   = 2'd2;
                step_d      = 3'd1;
              end else begin
                run.cmds[0] = mv(5'd4, 8'd40);
                run.cmds[1] = mv(5'd5, 8'd140);
                run.count   = 2'd2;
                step_d      = 3'd0;
                shake_d     = sc_inc;
                if (sc_inc == SHAKE_ROUNDS) begin
                  run.cmds[2] = stand_cmd();
                  run.count   = 2'd3;
                  seq_d       = SEQ_IDLE;
                end
              end
            end
          end
          default: begin
            seq_d = SEQ_IDLE;
          end
        endcase
      end
      OP_START_CAR: begin
        if (seq_q != SEQ_CAR) begin
          seq_d       = SEQ_CAR;
          step_d      = 3'd0;
          last_d      = now;
          run.cmds[0] = mv(5'd14, 8'd90);
          run.cmds[1] = mv(5'd20, 8'd90);
          run.count   = 2'd2;
        end
      end
      OP_START_CRAWLER: begin
        if (seq_q != SEQ_CRAWLER) begin
          seq_d       = SEQ_CRAWLER;
          step_d      = 3'd0;
          last_d      = now;
          run.cmds[0] = mv(5'd0, 8'd160);
          run.cmds[1] = mv(5'd1, 8'd20);
          run.count   = 2'd2;
        end
      end
      OP_RECOVER: begin
        case (fall_e'(fall_dir_i))
          FALL_FRONT: begin
            seq_d       = SEQ_FWD;
            step_d      = 3'd0;
            last_d      = now;
            run.cmds[0] = mv(5'd4, 8'd160);
            run.cmds[1] = mv(5'd5, 8'd20);
            run.count   = 2'd2;
          end
          FALL_REAR: begin
            seq_d       = SEQ_BACK;
            step_d      = 3'd0;
            last_d      = now;
            run.cmds[0] = mv(5'd0, 8'd150);
            run.cmds[1] = mv(5'd1, 8'd30);
            run.count   = 2'd2;
          end
          FALL_SHAKE: begin
            seq_d       = SEQ_SHAKE;
            step_d      = 3'd0;
            last_d      = now;
            shake_d     = 2'd0;
            run.cmds[0] = mv(5'd4, 8'd40);
            run.cmds[1] = mv(5'd5, 8'd140);
            run.count   = 2'd2;
          end
          default: begin
          end
        endcase
      end
      OP_STOP: begin
        seq_d   = SEQ_IDLE;
        step_d  = 3'd0;
        shake_d = 2'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= SEQ_IDLE;
      step_q  <= 3'd0;
      last_q  <= '0;
      shake_q <= 2'd0;
    end else if (accept) begin
      seq_q   <= seq_d;
      step_q  <= step_d;
      last_q  <= last_d;
      shake_q <= shake_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tsps_fifo.sv @@
// Small register queue of command runs between the front and back ends.
// Generic width and depth; uses no package.
`timescale 1ns / 1ps
`default_nettype none

module tsps_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d;
  logic [PtrW-1:0]  rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tsps_back.sv @@
// Back end of the timed servo pose sequencer: takes runs from the queue
// and sends their commands one word per cycle while ready. Uses tsps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsps_back
  import tsps_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire run_t  run_i,
  input  wire logic  empty_i,
  output logic       pop_o,
  output logic       cmd_valid_o,
  input  wire logic  cmd_ready_i,
  output cmd_t       cmd_o,
  output logic       cmd_last_o
);

  run_t       run_q;
  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  logic       fire;
  logic       load;

  assign cmd_valid_o = busy_q;
  assign cmd_o       = run_q.cmds[idx_q];
  assign cmd_last_o  = (idx_q == run_q.count - 2'd1);
  assign fire        = busy_q && cmd_ready_i;
  assign load        = (!busy_q || (fire && cmd_last_o)) && !empty_i;
  assign pop_o       = load;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end else if (fire) begin
      if (cmd_last_o) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      run_q <= run_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/timed_servo_pose_sequencer.sv @@
// Top level of the timed servo pose sequencer.
// Instantiates tsps_front, tsps_fifo and tsps_back; uses tsps_pkg.
//
// Each input word is an event with a millisecond timestamp: a tick, a start of
// the car or crawler sequence, a fall recovery with a direction, or a stop. The
// front end takes one event per cycle while the run queue is not full, updates
// the sequence state at once and queues the zero to three servo or stand
// commands that the event causes; the back end sends those commands one word
// per cycle while the output is ready, with tlast on the final command of each
// event. Events that give no command put nothing in the queue, and a two-entry
// run queue lets the input run ahead of a stalled output until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module timed_servo_pose_sequencer
  import tsps_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // fall_dir [1:0], now_ms [33:2], zero fill [39:34]
  input  wire logic [39:0] s_axis_tdata,
  // opcode [2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // servo_channel [4:0], servo_angle [12:5], zero fill [15:13]
  output logic [15:0]      m_axis_tdata,
  // command_kind [0]
  output logic [0:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int unsigned RunW = $bits(run_t);

  logic             push;
  logic             full;
  logic             empty;
  logic             pop;
  run_t             run_in;
  run_t             run_out;
  logic [RunW-1:0]  run_out_bits;
  cmd_t             cmd;

  tsps_front #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ev_valid_i(s_axis_tvalid),
    .ev_ready_o(s_axis_tready),
    .opcode_i  (s_axis_tuser),
    .fall_dir_i(s_axis_tdata[1:0]),
    .now_ms_i  (s_axis_tdata[33:2]),
    .push_o    (push),
    .run_o     (run_in),
    .full_i    (full)
  );

  tsps_fifo #(
    .Width(RunW),
    .Depth(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(run_in),
    .full_o (full),
    .pop_i  (pop),
    .rdata_o(run_out_bits),
    .empty_o(empty)
  );

  assign run_out = run_t'(run_out_bits);

  tsps_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .run_i      (run_out),
    .empty_i    (empty),
    .pop_o      (pop),
    .cmd_valid_o(m_axis_tvalid),
    .cmd_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .cmd_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, cmd.angle, cmd.chan};
  assign m_axis_tuser = cmd.kind;

endmodule

`default_nettype wire

@@ tb/timed_servo_pose_sequencer_test.sv @@
// Self-checking testbench for timed_servo_pose_sequencer.
// Predicts the servo and stand command words of each event and checks them in order.
// Depends on tsps_pkg and the timed_servo_pose_sequencer RTL.
`timescale 1ns / 1ps

module timed_servo_pose_sequencer_test;
  import tsps_pkg::*;

  localparam logic [2:0] OP_RESERVED   = 3'd5;
  localparam int         TARGET_EVENTS = 430;
  localparam int         CYCLE_LIMIT   = 300000;

  typedef struct packed {
    kind_e      kind;
    logic [4:0] chan;
    logic [7:0] angle;
    logic       last;
  } servo_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  seq_e        pose_seq = SEQ_IDLE;
  logic [2:0]  step_idx = '0;
  logic [31:0] step_time = '0;
  logic [1:0]  swing_count = '0;

  servo_cmd_t  event_cmds[$];
  servo_cmd_t  expected_cmds[$];

  int          events_sent = 0;
  int          cmds_checked = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          hold_off_len = 0;
  logic        offering = 1'b0;

  timed_servo_pose_sequencer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void emit(kind_e kind, logic [4:0] chan, logic [7:0] angle);
    servo_cmd_t c;
    c.kind  = kind;
    c.chan  = chan;
    c.angle = angle;
    c.last  = 1'b0;
    event_cmds.push_back(c);
  endfunction

  function automatic void move_pair(logic [4:0] chan_a, logic [7:0] angle_a,
                                    logic [4:0] chan_b, logic [7:0] angle_b);
    emit(KIND_MOVE, chan_a, angle_a);
    emit(KIND_MOVE, chan_b, angle_b);
  endfunction

  function automatic void enter_seq(seq_e seq, logic [31:0] now);
    pose_seq  = seq;
    step_idx  = 3'd0;
    step_time = now;
  endfunction

  function automatic void next_step(logic [31:0] now);
    step_idx  = step_idx + 3'd1;
    step_time = now;
  endfunction

  function automatic void tick_sequence(logic [31:0] now);
    logic [31:0] el;
    el = now - step_time;
    case (pose_seq)
      SEQ_IDLE: begin
      end
      SEQ_CAR: begin
        if (step_idx == 3'd0 && el >= DLY_300) begin
          emit(KIND_MOVE, 5'd24, 8'd0);
          next_step(now);
        end else if (step_idx == 3'd1 && el >= DLY_500) begin
          move_pair(5'd14, 8'd0, 5'd20, 8'd180);
          next_step(now);
        end else if (step_idx == 3'd2 && el >= DLY_500) begin
          move_pair(5'd15, 8'd0, 5'd21, 8'd180);
          next_step(now);
        end else if (step_idx == 3'd3 && el >= DLY_500) begin
          move_pair(5'd2, 8'd0, 5'd8, 8'd180);
          next_step(now);
        end else if (step_idx == 3'd4 && el >= DLY_500) begin
          move_pair(5'd3, 8'd180, 5'd9, 8'd0);
          next_step(now);
        end else if (step_idx == 3'd5 && el >= DLY_600) begin
          move_pair(5'd4, 8'd90, 5'd10, 8'd90);
          emit(KIND_MOVE, 5'd26, 8'd0);
          pose_seq = SEQ_IDLE;
        end
      end
      SEQ_CRAWLER: begin
        if (step_idx == 3'd0 && el >= DLY_300) begin
          move_pair(5'd2, 8'd160, 5'd3, 8'd20);
          next_step(now);
        end else if (step_idx == 3'd1 && el >= DLY_300) begin
          move_pair(5'd4, 8'd150, 5'd5, 8'd30);
          next_step(now);
        end else if (step_idx == 3'd2 && el >= DLY_200) begin
          pose_seq = SEQ_IDLE;
        end
      end
      SEQ_FWD: begin
        if (step_idx == 3'd0 && el >= DLY_500) begin
          move_pair(5'd4, 8'd40, 5'd5, 8'd140);
          next_step(now);
        end else if (step_idx == 3'd1 && el >= DLY_300) begin
          pose_seq = SEQ_IDLE;
          emit(KIND_STAND, 5'd0, 8'd0);
        end
      end
      SEQ_BACK: begin
        if (step_idx == 3'd0 && el >= DLY_400) begin
          move_pair(5'd2, 8'd160, 5'd3, 8'd20);
          next_step(now);
        end else if (step_idx == 3'd1 && el >= DLY_300) begin
          pose_seq = SEQ_IDLE;
          emit(KIND_STAND, 5'd0, 8'd0);
        end
      end
      SEQ_SHAKE: begin
        if (el >= DLY_100) begin
          step_time = now;
          if (step_idx == 3'd0) begin
            move_pair(5'd4, 8'd140, 5'd5, 8'd40);
            step_idx = 3'd1;
          end else begin
            move_pair(5'd4, 8'd40, 5'd5, 8'd140);
            step_idx    = 3'd0;
            swing_count = swing_count + 2'd1;
            if (swing_count >= SHAKE_ROUNDS) begin
              pose_seq = SEQ_IDLE;
              emit(KIND_STAND, 5'd0, 8'd0);
            end
          end
        end
      end
      default: begin
        pose_seq = SEQ_IDLE;
      end
    endcase
  endfunction

  function automatic void predict_event(logic [2:0] op, logic [1:0] dir, logic [31:0] now);
    servo_cmd_t c;
    event_cmds.delete();
    case (op)
      OP_TICK: begin
        tick_sequence(now);
      end
      OP_START_CAR: begin
        if (pose_seq != SEQ_CAR) begin
          enter_seq(SEQ_CAR, now);
          move_pair(5'd14, 8'd90, 5'd20, 8'd90);
        end
      end
      OP_START_CRAWLER: begin
        if (pose_seq != SEQ_CRAWLER) begin
          enter_seq(SEQ_CRAWLER, now);
          move_pair(5'd0, 8'd160, 5'd1, 8'd20);
        end
      end
      OP_RECOVER: begin
        case (dir)
          FALL_FRONT: begin
            enter_seq(SEQ_FWD, now);
            move_pair(5'd4, 8'd160, 5'd5, 8'd20);
          end
          FALL_REAR: begin
            enter_seq(SEQ_BACK, now);
            move_pair(5'd0, 8'd150, 5'd1, 8'd30);
          end
          FALL_SHAKE: begin
            enter_seq(SEQ_SHAKE, now);
            swing_count = 2'd0;
            move_pair(5'd4, 8'd40, 5'd5, 8'd140);
          end
          default: begin
          end
        endcase
      end
      OP_STOP: begin
        pose_seq    = SEQ_IDLE;
        step_idx    = 3'd0;
        swing_count = 2'd0;
      end
      default: begin
      end
    endcase
    foreach (event_cmds[i]) begin
      c      = event_cmds[i];
      c.last = (i == event_cmds.size() - 1);
      expected_cmds.push_back(c);
    end
  endfunction

  task automatic sender_idle();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_event(logic [2:0] op, logic [1:0] dir, logic [31:0] now);
    logic ready_seen;
    if (burst_left == 0) begin
      sender_idle();
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    offering = 1'b1;
    s_axis_tdata <= {6'd0, now, dir};
    s_axis_tuser <= op;
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready;
      @(posedge clk_i);
    end while (!ready_seen);
    predict_event(op, dir, now);
    events_sent++;
    burst_left--;
  endtask

  task automatic wait_for_drain();
    sender_idle();
    @(posedge clk_i);
    while (expected_cmds.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_step_ms();
    int r;
    r = $urandom_range(0, 11);
    if (r < 2) return $urandom_range(0, 99);
    if (r == 2) return $urandom;
    if (r < 7) return $urandom_range(300, 650);
    return $urandom_range(100, 650);
  endfunction

  // Start at the top of the time range so the car steps cross the wrap.
  task automatic test_car_sequence();
    logic [31:0] t;
    t = 32'hFFFF_FF00;
    send_event(OP_START_CAR, FALL_NONE, t);
    send_event(OP_START_CAR, FALL_SHAKE, t + 32'd5);
    send_event(OP_TICK, FALL_NONE, t + 32'd299);
    t = t + 32'd300;
    send_event(OP_TICK, FALL_NONE, t);
    repeat (4) begin
      t = t + 32'd500;
      send_event(OP_TICK, FALL_NONE, t);
    end
    send_event(OP_TICK, FALL_NONE, t + 32'd600);
  endtask

  task automatic test_crawler_sequence();
    send_event(OP_START_CRAWLER, FALL_NONE, 32'd0);
    send_event(OP_TICK, FALL_NONE, 32'd300);
    send_event(OP_TICK, FALL_NONE, 32'd600);
    send_event(OP_TICK, FALL_NONE, 32'd800);
  endtask

  task automatic test_fall_recovery();
    send_event(OP_RECOVER, FALL_NONE, 32'hFFFF_FFFF);
    send_event(OP_RECOVER, FALL_FRONT, 32'd100);
    send_event(OP_TICK, FALL_NONE, 32'd600);
    send_event(OP_TICK, FALL_NONE, 32'd900);
    send_event(OP_RECOVER, FALL_REAR, 32'd1000);
    send_event(OP_STOP, FALL_NONE, 32'd1001);
    send_event(OP_TICK, FALL_NONE, 32'd1401);
  endtask

  task automatic test_reserved_opcode();
    send_event(OP_RESERVED, FALL_SHAKE, 32'hFFFF_FFFF);
  endtask

  task automatic test_shake_recovery();
    send_event(OP_RECOVER, FALL_SHAKE, 32'h8000_0000);
    send_event(OP_TICK, FALL_NONE, 32'h8000_0063);
    send_event(OP_TICK, FALL_NONE, 32'h8000_0064);
    send_event(OP_TICK, FALL_NONE, 32'h8000_00C8);
  endtask

  // The receiver holds off while a shake and a car run are pushed in, so the
  // run queue fills and the input stalls; then the sender waits for the drain.
  task automatic test_output_backpressure();
    logic [31:0] t;
    t = $urandom;
    hold_off_len = 300;
    send_event(OP_RECOVER, FALL_SHAKE, t);
    repeat (6) begin
      t = t + 32'd100;
      send_event(OP_TICK, FALL_NONE, t);
    end
    send_event(OP_START_CAR, FALL_NONE, t);
    t = t + 32'd300;
    send_event(OP_TICK, FALL_NONE, t);
    repeat (4) begin
      t = t + 32'd500;
      send_event(OP_TICK, FALL_NONE, t);
    end
    wait_for_drain();
  endtask

  task automatic run_random_session();
    logic [2:0]  start_op;
    logic [1:0]  start_dir;
    logic [31:0] t;
    int          kind;
    int          r;
    kind = $urandom_range(0, 4);
    start_dir = 2'($urandom_range(0, 3));
    case (kind)
      0: start_op = OP_START_CAR;
      1: start_op = OP_START_CRAWLER;
      default: begin
        start_op  = OP_RECOVER;
        start_dir = (kind == 2) ? FALL_FRONT : (kind == 3) ? FALL_REAR : FALL_SHAKE;
      end
    endcase
    t = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000) : $urandom;
    send_event(start_op, start_dir, t);
    repeat ($urandom_range(2, 9)) begin
      r = $urandom_range(0, 19);
      t = t + random_step_ms();
      if (r == 0) send_event(OP_STOP, 2'($urandom_range(0, 3)), t);
      else if (r < 3) send_event(start_op, start_dir, t);
      else send_event(OP_TICK, 2'($urandom_range(0, 3)), t);
    end
  endtask

  task automatic test_random_sessions();
    while (events_sent < TARGET_EVENTS) begin
      if ($urandom_range(0, 5) == 0) begin
        send_event(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), $urandom);
      end else begin
        run_random_session();
      end
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  initial begin
    servo_cmd_t got;
    servo_cmd_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.kind  = kind_e'(m_axis_tuser[0]);
        got.chan  = m_axis_tdata[4:0];
        got.angle = m_axis_tdata[12:5];
        got.last  = m_axis_tlast;
        if (expected_cmds.size() == 0) begin
          error_count++;
          $display("%0t: unexpected word, expected none, actual kind %0d chan %0d angle %0d last %0d",
                   $time, got.kind, got.chan, got.angle, got.last);
        end else begin
          want = expected_cmds.pop_front();
          cmds_checked++;
          check_field("command_kind", want.kind, got.kind);
          check_field("servo_channel", want.chan, got.chan);
          check_field("servo_angle", want.angle, got.angle);
          check_field("last_of_run", want.last, got.last);
        end
      end
    end
  end

  initial begin
    int   seg_mode;
    int   seg_len;
    logic rdy;
    forever begin
      seg_mode = $urandom_range(0, 3);
      seg_len  = $urandom_range(4, 40);
      for (int i = 0; i < seg_len && hold_off_len == 0; i++) begin
        case (seg_mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = (i % 4 == 0);
          default: rdy = i[0];
        endcase
        m_axis_tready <= rdy;
        @(posedge clk_i);
      end
      if (hold_off_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off_len) @(posedge clk_i);
        hold_off_len = 0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_car_sequence();
    test_crawler_sequence();
    test_fall_recovery();
    test_reserved_opcode();
    test_shake_recovery();
    wait_for_drain();
    test_output_backpressure();
    test_random_sessions();
    wait_for_drain();
    repeat (20) @(posedge clk_i);
    if (expected_cmds.size() != 0) begin
      error_count += expected_cmds.size();
      $display("%0t: %0d command words never arrived", $time, expected_cmds.size());
    end
    $display("Sent %0d events and checked %0d command words over car, crawler,",
             events_sent, cmds_checked);
    $display("fall, shake and stop runs with input gaps and output stalls.");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
